>>> src/aes_prf_pkg.sv
// ----------------------------------------------------------------------------
// aes_prf_pkg: shared types, constants and AES functions
// Byte k of a 128-bit block sits at bits 8k+7:8k, round key word j at 32j.
// ----------------------------------------------------------------------------
`default_nettype none
package aes_prf_pkg;

  localparam int NumRounds = 10;

  typedef enum logic [2:0] {
    MODE_ECB    = 3'd0,
    MODE_DOUBLE = 3'd1,
    MODE_DELTA  = 3'd2,
    MODE_EXPAND = 3'd3,
    MODE_COPY   = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    REG_KEY0_W0 = 3'd0,
    REG_KEY0_W1 = 3'd1,
    REG_KEY1_W0 = 3'd2,
    REG_KEY1_W1 = 3'd3,
    REG_MODE    = 3'd4,
    REG_REPEAT  = 3'd5
  } reg_idx_t;

  // what the output stage does with a finished job
  typedef enum logic [2:0] {
    OP_ENC  = 3'd0,  // emit E
    OP_ENCX = 3'd1,  // emit E ^ block
    OP_HOLD = 3'd2,  // hold := E, no beat
    OP_MIX  = 3'd3,  // emit hold ^ E, hold := hold ^ E
    OP_MIXX = 3'd4,  // emit hold ^ block
    OP_COPY = 3'd5   // emit block
  } op_t;

  typedef struct packed {
    logic [127:0] st;
    logic [127:0] blk;
    op_t          op;
    logic         ksel;
    logic         last;
    logic         bdone;
  } job_t;

  typedef logic [1:0][127:0] keys_t;

  localparam logic [7:0] RCON [1:10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                         8'h20, 8'h40, 8'h80, 8'h1B, 8'h36};

  localparam logic [3:0] SHUF [16] = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd0, 4'd8,
                                       4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14,
                                       4'd15, 4'd7};

  function automatic logic [7:0] gf_mul(input logic [7:0] a_in, input logic [7:0] b_in);
    logic [7:0] a, b, r;
    a = a_in;
    b = b_in;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) r = r ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
      b = b >> 1;
    end
    return r;
  endfunction

  // inverse as x^254, then the affine map; folds to a constant table
  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] p, r, s;
    p = x;
    r = 8'h01;
    for (int i = 0; i < 7; i++) begin
      p = gf_mul(p, p);
      r = gf_mul(r, p);
    end
    if (x == 8'h00) r = 8'h00;
    s = r;
    for (int i = 0; i < 4; i++) begin
      r = {r[6:0], r[7]};
      s = s ^ r;
    end
    return s ^ 8'h63;
  endfunction

  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] t, w0, w1, w2, w3;
    t = {k[103:96], k[127:104]};
    t = {sbox(t[31:24]), sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0])} ^ {24'd0, rc};
    w0 = k[31:0] ^ t;
    w1 = k[63:32] ^ w0;
    w2 = k[95:64] ^ w1;
    w3 = k[127:96] ^ w2;
    return {w3, w2, w1, w0};
  endfunction

  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic final_rnd);
    logic [7:0] t [16];
    logic [127:0] o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[4*c+r] = sbox(s[8*(4*((c+r)%4)+r) +: 8]);
    for (int c = 0; c < 4; c++) begin
      if (final_rnd) begin
        o[32*c +: 32] = {t[4*c+3], t[4*c+2], t[4*c+1], t[4*c]};
      end else begin
        o[32*c +: 8]    = gf_mul(t[4*c], 8'h02) ^ gf_mul(t[4*c+1], 8'h03)
                          ^ t[4*c+2] ^ t[4*c+3];
        o[32*c+8 +: 8]  = t[4*c] ^ gf_mul(t[4*c+1], 8'h02)
                          ^ gf_mul(t[4*c+2], 8'h03) ^ t[4*c+3];
        o[32*c+16 +: 8] = t[4*c] ^ t[4*c+1] ^ gf_mul(t[4*c+2], 8'h02)
                          ^ gf_mul(t[4*c+3], 8'h03);
        o[32*c+24 +: 8] = gf_mul(t[4*c], 8'h03) ^ t[4*c+1] ^ t[4*c+2]
                          ^ gf_mul(t[4*c+3], 8'h02);
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] shuffle(input logic [127:0] b);
    logic [127:0] o;
    for (int i = 0; i < 16; i++) o[8*i +: 8] = b[8*SHUF[i] +: 8];
    return o;
  endfunction

endpackage
`default_nettype wire

>>> src/aes_prf_cell.sv
// ----------------------------------------------------------------------------
// aes_prf_cell: one AES round of the cell chain
// Derives its own round keys from the neighbor's and runs one round per beat.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_prf_cell #(
  parameter int ROUND = 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 adv,
  input  wire logic                 vld_in,
  input  wire aes_prf_pkg::job_t    job_in,
  input  wire aes_prf_pkg::keys_t   key_in,
  output logic                      vld_out,
  output aes_prf_pkg::job_t         job_out,
  output aes_prf_pkg::keys_t        key_out
);

  aes_prf_pkg::keys_t key_r;
  aes_prf_pkg::job_t  job_r, job_nxt;
  logic               vld_r;

  // keys ripple down the chain every cycle
  always_ff @(posedge clk) begin
    key_r[0] <= aes_prf_pkg::key_step(key_in[0], aes_prf_pkg::RCON[ROUND]);
    key_r[1] <= aes_prf_pkg::key_step(key_in[1], aes_prf_pkg::RCON[ROUND]);
  end

  always_comb begin
    job_nxt    = job_in;
    job_nxt.st = aes_prf_pkg::aes_round(job_in.st, ROUND == aes_prf_pkg::NumRounds)
                 ^ key_r[job_in.ksel];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) job_r <= job_nxt;
  end

  assign vld_out = vld_r;
  assign job_out = job_r;
  assign key_out = key_r;

endmodule
`default_nettype wire

>>> src/aes_prf_issue.sv
// ----------------------------------------------------------------------------
// aes_prf_issue: job sequencer
// Holds the current block and sends one encryption job per beat into the chain.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_prf_issue #(
  parameter int MAX_REPEAT = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 adv,
  input  wire logic                 keys_ok,
  input  wire logic [2:0]           mode,
  input  wire logic [6:0]           repeat_count,
  input  wire aes_prf_pkg::keys_t   key_raw,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [127:0]         in_tdata,
  input  wire logic                 in_tlast,
  output logic                      vld_out,
  output aes_prf_pkg::job_t         job_out
);

  logic                 cur_vld_r, cur_vld_nxt;
  logic [127:0]         blk_r, blk_nxt;
  aes_prf_pkg::mode_t   mode_r, mode_nxt;
  logic [6:0]           num_r, num_nxt, idx_r, idx_nxt, cnt;
  logic                 bdone_r, bdone_nxt;
  logic                 is_last, accept, issue;
  aes_prf_pkg::op_t     op;
  logic                 ksel;

  always_comb begin
    cnt = repeat_count;
    if (repeat_count == 7'd0) cnt = 7'd1;
    if (repeat_count > 7'(MAX_REPEAT)) cnt = 7'(MAX_REPEAT);
  end

  assign is_last   = (idx_r == num_r - 7'd1);
  assign in_tready = keys_ok && (!cur_vld_r || (adv && is_last));
  assign accept    = in_tvalid && in_tready;
  assign issue     = cur_vld_r && adv;

  always_comb begin
    op   = aes_prf_pkg::OP_ENC;
    ksel = 1'b0;
    case (mode_r)
      aes_prf_pkg::MODE_DOUBLE: begin
        op   = aes_prf_pkg::OP_ENCX;
        ksel = idx_r[0];
      end
      aes_prf_pkg::MODE_DELTA: begin
        if (idx_r == 7'd0) begin
          op = aes_prf_pkg::OP_HOLD;
        end else if (idx_r == 7'd1) begin
          op   = aes_prf_pkg::OP_MIX;
          ksel = 1'b1;
        end else begin
          op = aes_prf_pkg::OP_MIXX;
        end
      end
      aes_prf_pkg::MODE_EXPAND: op = aes_prf_pkg::OP_ENCX;
      aes_prf_pkg::MODE_COPY:
        op = (idx_r == 7'd0) ? aes_prf_pkg::OP_COPY : aes_prf_pkg::OP_ENCX;
      default: op = aes_prf_pkg::OP_ENC;
    endcase
  end

  always_comb begin
    job_out.st    = blk_r ^ key_raw[ksel];
    job_out.blk   = blk_r;
    job_out.op    = op;
    job_out.ksel  = ksel;
    job_out.last  = is_last;
    job_out.bdone = is_last && bdone_r;
  end
  assign vld_out = cur_vld_r;

  always_comb begin
    cur_vld_nxt = cur_vld_r;
    blk_nxt     = blk_r;
    mode_nxt    = mode_r;
    num_nxt     = num_r;
    idx_nxt     = idx_r;
    bdone_nxt   = bdone_r;
    if (issue) begin
      idx_nxt = idx_r + 7'd1;
      if (op == aes_prf_pkg::OP_ENCX && (mode_r == aes_prf_pkg::MODE_EXPAND ||
                                         mode_r == aes_prf_pkg::MODE_COPY))
        blk_nxt = aes_prf_pkg::shuffle(blk_r);
      if (is_last) cur_vld_nxt = 1'b0;
    end
    if (accept) begin
      cur_vld_nxt = 1'b1;
      blk_nxt     = in_tdata;
      bdone_nxt   = in_tlast;
      idx_nxt     = 7'd0;
      case (mode)
        aes_prf_pkg::MODE_DOUBLE: begin
          mode_nxt = aes_prf_pkg::MODE_DOUBLE;
          num_nxt  = 7'd2;
        end
        aes_prf_pkg::MODE_DELTA: begin
          mode_nxt = aes_prf_pkg::MODE_DELTA;
          num_nxt  = 7'd3;
        end
        aes_prf_pkg::MODE_EXPAND: begin
          mode_nxt = aes_prf_pkg::MODE_EXPAND;
          num_nxt  = cnt;
        end
        aes_prf_pkg::MODE_COPY: begin
          mode_nxt = aes_prf_pkg::MODE_COPY;
          num_nxt  = cnt;
        end
        default: begin
          mode_nxt = aes_prf_pkg::MODE_ECB;
          num_nxt  = 7'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r   <= blk_nxt;
    mode_r  <= mode_nxt;
    num_r   <= num_nxt;
    idx_r   <= idx_nxt;
    bdone_r <= bdone_nxt;
  end

endmodule
`default_nettype wire

>>> src/aes128_prf_expander.sv
// ----------------------------------------------------------------------------
// aes128_prf_expander: AES-128 PRF / block expander
// Top level: configuration registers, issuer, ten round cells, output stage.
// ----------------------------------------------------------------------------
// Each job runs through a chain of ten round cells, one AES round per cell,
// and a new job enters every cycle while the output does not stall the chain.
// A block needs 1 job in ECB, 2 in double mode, 3 in double delta and
// repeat_count (clamped to 1..MAX_REPEAT) in the expand modes; its results pass
// the ten cells and the output register. After reset and after every key
// write, no block is taken until the round keys have rippled down the chain.
`default_nettype none
module aes128_prf_expander #(
  parameter int MAX_REPEAT = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [63:0]   cfg_data,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [127:0]  in_tdata,   // block_lo, block_hi
  input  wire logic          in_tlast,   // batch_end
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [127:0]       out_tdata,  // out_lo, out_hi
  output logic               out_tlast,  // run_last
  output logic               out_tuser   // batch_done
);

  logic [63:0]  k0w0_r, k0w1_r, k1w0_r, k1w1_r;
  logic [2:0]   mode_r;
  logic [6:0]   rep_r;
  logic [3:0]   settle_r;
  logic         cfg_we, adv;
  aes_prf_pkg::keys_t key_raw;

  logic               vld [aes_prf_pkg::NumRounds+1];
  aes_prf_pkg::job_t  job [aes_prf_pkg::NumRounds+1];
  aes_prf_pkg::keys_t key [aes_prf_pkg::NumRounds+1];

  logic [127:0] hold_r, hold_nxt, od_r, od_nxt;
  logic         ov_r, ov_nxt, ol_r, ol_nxt, ou_r, ou_nxt;
  aes_prf_pkg::job_t  fin;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k0w0_r   <= '0;
      k0w1_r   <= '0;
      k1w0_r   <= '0;
      k1w1_r   <= '0;
      mode_r   <= aes_prf_pkg::MODE_ECB;
      rep_r    <= 7'd1;
      settle_r <= 4'(aes_prf_pkg::NumRounds + 1);
    end else begin
      if (settle_r != 4'd0) settle_r <= settle_r - 4'd1;
      if (cfg_we) begin
        unique case (cfg_index)
          aes_prf_pkg::REG_KEY0_W0: k0w0_r <= cfg_data;
          aes_prf_pkg::REG_KEY0_W1: k0w1_r <= cfg_data;
          aes_prf_pkg::REG_KEY1_W0: k1w0_r <= cfg_data;
          aes_prf_pkg::REG_KEY1_W1: k1w1_r <= cfg_data;
          aes_prf_pkg::REG_MODE:    mode_r <= cfg_data[2:0];
          aes_prf_pkg::REG_REPEAT:  rep_r  <= cfg_data[6:0];
          default: ;
        endcase
        if (cfg_index == aes_prf_pkg::REG_KEY0_W0 || cfg_index == aes_prf_pkg::REG_KEY0_W1 ||
            cfg_index == aes_prf_pkg::REG_KEY1_W0 || cfg_index == aes_prf_pkg::REG_KEY1_W1)
          settle_r <= 4'(aes_prf_pkg::NumRounds + 1);
      end
    end
  end

  assign key_raw[0] = {k0w0_r, k0w1_r};
  assign key_raw[1] = {k1w0_r, k1w1_r};
  assign key[0]     = key_raw;

  // whole chain moves together; stalls only when a result waits
  assign adv = !ov_r || out_tready;

  aes_prf_issue #(.MAX_REPEAT(MAX_REPEAT)) u_issue (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .keys_ok      (settle_r == 4'd0),
    .mode         (mode_r),
    .repeat_count (rep_r),
    .key_raw      (key_raw),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .vld_out      (vld[0]),
    .job_out      (job[0])
  );

  for (genvar g = 1; g <= aes_prf_pkg::NumRounds; g++) begin : g_cell
    aes_prf_cell #(.ROUND(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .vld_in  (vld[g-1]),
      .job_in  (job[g-1]),
      .key_in  (key[g-1]),
      .vld_out (vld[g]),
      .job_out (job[g]),
      .key_out (key[g])
    );
  end

  assign fin = job[aes_prf_pkg::NumRounds];

  always_comb begin
    hold_nxt = hold_r;
    od_nxt   = od_r;
    ol_nxt   = ol_r;
    ou_nxt   = ou_r;
    ov_nxt   = ov_r && !out_tready;
    if (adv && vld[aes_prf_pkg::NumRounds]) begin
      ov_nxt = 1'b1;
      ol_nxt = fin.last;
      ou_nxt = fin.bdone;
      case (fin.op)
        aes_prf_pkg::OP_ENCX: od_nxt = fin.st ^ fin.blk;
        aes_prf_pkg::OP_HOLD: begin
          hold_nxt = fin.st;
          ov_nxt   = 1'b0;
        end
        aes_prf_pkg::OP_MIX: begin
          od_nxt   = hold_r ^ fin.st;
          hold_nxt = hold_r ^ fin.st;
        end
        aes_prf_pkg::OP_MIXX: od_nxt = hold_r ^ fin.blk;
        aes_prf_pkg::OP_COPY: od_nxt = fin.blk;
        default:              od_nxt = fin.st;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    od_r   <= od_nxt;
    ol_r   <= ol_nxt;
    ou_r   <= ou_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;
  assign out_tuser  = ou_r;

endmodule
`default_nettype wire
